>>> rtl/core/ger_pkg.sv
// shared types and constants for the group echo replicator
// no dependencies; imported by ger_cell, ger_ctrl and the top level
`default_nettype none

package ger_pkg;

  localparam int AddrW   = 32;
  localparam int PortW   = 16;
  localparam int TimeW   = 32;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 2;

  // mode register values; the undefined code behaves as the timeout mode
  localparam logic [1:0] MODE_INFINITE = 2'd0;
  localparam logic [1:0] MODE_SINGLE   = 2'd1;

  localparam logic FUNC_PACKET = 1'b0;
  localparam logic FUNC_JOIN   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE        = 2'd0,
    CFG_ECHO_PORT   = 2'd1,
    CFG_TIMEOUT     = 2'd2,
    CFG_ECHO_CLIENT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_SINGLE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] src_addr;
    logic [PortW-1:0] src_port;
    logic [TimeW-1:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [AddrW-1:0] dest_addr;
    logic [PortW-1:0] dest_port;
    logic             last;
  } out_word_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             adv;
    logic             capture;
    logic             kill;
    logic             is_join;
    logic             aging;
    logic             skip_src;
    logic [TimeW-1:0] timeout;
    logic [TimeW-1:0] now_time;
    logic [AddrW-1:0] src_addr;
    logic [PortW-1:0] src_port;
  } cell_cmd_t;

  // per cell answer, zero unless the cell holds the token (match aside)
  typedef struct packed {
    logic             match;
    logic             cand;
    logic [AddrW-1:0] addr;
    logic [PortW-1:0] port;
  } cell_rsp_t;

  // link between neighboring cells
  typedef struct packed {
    logic tok;
    logic need;
  } link_t;

endpackage

`default_nettype wire

>>> rtl/core/ger_stream_if.sv
// valid/ready stream interface carrying one word of a package type
// word type is supplied by the instantiating testbench or parent
`default_nettype none

interface ger_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ger_cell.sv
// one table slot: endpoint, stamp, valid bit and the scan token
// depends on ger_pkg
`default_nettype none

module ger_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ger_pkg::cell_cmd_t cmd,
  input  wire ger_pkg::link_t     link_in,
  output ger_pkg::link_t          link_out,
  output ger_pkg::cell_rsp_t      rsp
);
  import ger_pkg::*;

  logic             valid_r;
  logic             tok_r;
  logic             need_r;
  logic             match_r;
  logic [AddrW-1:0] addr_r;
  logic [PortW-1:0] port_r;
  logic [TimeW-1:0] stamp_r;

  logic             hit;
  logic             ins;
  logic             is_src;
  logic             v_lrn;
  logic [AddrW-1:0] addr_lrn;
  logic [PortW-1:0] port_lrn;
  logic [TimeW-1:0] stamp_lrn;
  logic [TimeW-1:0] age;
  logic             expire;
  logic             serve;

  always_comb begin
    hit       = valid_r && (addr_r == cmd.src_addr) && (port_r == cmd.src_port);
    // first free slot reached while the source is still unplaced takes it
    ins       = need_r && !valid_r;
    is_src    = match_r || ins;
    v_lrn     = valid_r || ins;
    addr_lrn  = ins ? cmd.src_addr : addr_r;
    port_lrn  = ins ? cmd.src_port : port_r;
    stamp_lrn = is_src ? cmd.now_time : stamp_r;
    age       = cmd.now_time - stamp_lrn;
    expire    = cmd.aging && (age >= cmd.timeout);
    serve     = v_lrn && !cmd.is_join && !(cmd.skip_src && is_src);

    link_out.tok  = tok_r;
    link_out.need = need_r && valid_r;

    rsp.match = hit;
    rsp.cand  = tok_r && serve && !expire;
    rsp.addr  = tok_r ? addr_lrn : '0;
    rsp.port  = tok_r ? port_lrn : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
      need_r  <= 1'b0;
    end else begin
      if (cmd.adv) begin
        tok_r  <= link_in.tok;
        need_r <= link_in.need;
      end
      if (tok_r && cmd.adv) begin
        valid_r <= v_lrn && !(serve && expire);
      end else if (cmd.kill && match_r) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match_r <= hit;
    end
    if (tok_r && cmd.adv) begin
      addr_r  <= addr_lrn;
      port_r  <= port_lrn;
      stamp_r <= stamp_lrn;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ger_ctrl.sv
// sequencer: config registers, input capture, token launch and result buffering
// depends on ger_pkg and ger_stream_if
`default_nettype none

module ger_ctrl #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  ger_stream_if.sink                   in_ch,
  ger_stream_if.source                 out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [ger_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [ger_pkg::CfgW-1:0]    cfg_data,
  input  wire ger_pkg::cell_rsp_t      rsp [TABLE_DEPTH],
  input  wire ger_pkg::link_t          tail,
  output ger_pkg::cell_cmd_t           cmd,
  output ger_pkg::link_t               head
);
  import ger_pkg::*;

  state_t           state_r, state_nxt;
  in_word_t         src_r, src_nxt;
  logic [1:0]       mode_r;
  logic [PortW-1:0] echo_port_r;
  logic [TimeW-1:0] timeout_r;
  logic             echo_client_r;

  logic             pend_v_r, pend_v_nxt;
  logic [AddrW-1:0] pend_addr_r, pend_addr_nxt;
  logic [PortW-1:0] pend_port_r, pend_port_nxt;
  logic             out_v_r, out_v_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             hit_any;
  logic             cand_any;
  logic [AddrW-1:0] cand_addr;
  logic [PortW-1:0] cand_port;
  logic             out_free;
  logic             need_push;
  logic             step;

  // only the token holder drives nonzero cand, addr and port; any cell may raise match
  always_comb begin
    hit_any   = 1'b0;
    cand_any  = 1'b0;
    cand_addr = '0;
    cand_port = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_any   = hit_any | rsp[i].match;
      cand_any  = cand_any | rsp[i].cand;
      cand_addr = cand_addr | rsp[i].addr;
      cand_port = cand_port | rsp[i].port;
    end
  end

  function automatic logic [PortW-1:0] sel_port(input logic [PortW-1:0] ep,
                                                input logic [PortW-1:0] own);
    sel_port = (ep != '0) ? ep : own;
  endfunction

  assign out_free  = !out_v_r || out_ch.ready;
  assign need_push = cand_any && pend_v_r;
  assign step      = !need_push || out_free;

  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    pend_port_nxt = pend_port_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    in_ch.ready   = 1'b0;
    head.tok      = 1'b0;
    head.need     = !hit_any;

    cmd.adv      = 1'b0;
    cmd.capture  = 1'b0;
    cmd.kill     = 1'b0;
    cmd.is_join  = (src_r.func == FUNC_JOIN);
    cmd.aging    = (mode_r != MODE_INFINITE);
    cmd.skip_src = !echo_client_r;
    cmd.timeout  = timeout_r;
    cmd.now_time = src_r.now_time;
    cmd.src_addr = src_r.src_addr;
    cmd.src_port = src_r.src_port;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          src_nxt   = in_ch.data;
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.capture = 1'b1;
        cmd.adv     = 1'b1;
        if (src_r.func == FUNC_PACKET && mode_r == MODE_SINGLE) begin
          state_nxt = ST_SINGLE;
        end else begin
          head.tok  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SINGLE: begin
        // learn then drop nets out to removing a hit entry
        if (!echo_client_r) begin
          cmd.kill  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.kill               = 1'b1;
          out_v_nxt              = 1'b1;
          out_word_nxt.dest_addr = src_r.src_addr;
          out_word_nxt.dest_port = sel_port(echo_port_r, src_r.src_port);
          out_word_nxt.last      = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // one destination is held back until the next shows whether it is last
        cmd.adv = step;
        if (step) begin
          if (need_push) begin
            out_v_nxt              = 1'b1;
            out_word_nxt.dest_addr = pend_addr_r;
            out_word_nxt.dest_port = pend_port_r;
            out_word_nxt.last      = 1'b0;
          end
          if (cand_any) begin
            pend_v_nxt    = 1'b1;
            pend_addr_nxt = cand_addr;
            pend_port_nxt = sel_port(echo_port_r, cand_port);
          end
          if (tail.tok) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt              = 1'b1;
          out_word_nxt.dest_addr = pend_addr_r;
          out_word_nxt.dest_port = pend_port_r;
          out_word_nxt.last      = 1'b1;
          pend_v_nxt             = 1'b0;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
      mode_r        <= MODE_SINGLE;
      echo_port_r   <= '0;
      timeout_r     <= '0;
      echo_client_r <= 1'b1;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MODE:        mode_r        <= cfg_data[1:0];
          CFG_ECHO_PORT:   echo_port_r   <= cfg_data[PortW-1:0];
          CFG_TIMEOUT:     timeout_r     <= cfg_data[TimeW-1:0];
          CFG_ECHO_CLIENT: echo_client_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_port_r <= pend_port_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_word_r;

endmodule

`default_nettype wire

>>> rtl/core/group_echo_replicator.sv
// top level: sequencer plus a chain of table cells passing a scan token
// depends on ger_pkg, ger_stream_if, ger_cell and ger_ctrl
//
//   port     dir    handshake      word
//   in_ch    sink   valid/ready    func, src_addr, src_port, now_time
//   out_ch   source valid/ready    dest_addr, dest_port, last
//   cfg_*    in     cfg_we         cfg_index, cfg_data
//
// a join or group-mode packet steps through capture, parallel endpoint compare,
// and one cell per cycle as the token walks the chain, then the held last
// destination is released. a single-mode packet steps through capture, compare
// and removal of a hit entry. the token halts while out_ch stalls.
// synchronous reset empties the table at once; config writes are taken any time.
`default_nettype none

module group_echo_replicator #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ger_stream_if.sink                       in_ch,
  ger_stream_if.source                     out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [ger_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [ger_pkg::CfgW-1:0]    cfg_data
);
  import ger_pkg::*;

  cell_cmd_t cmd;
  cell_rsp_t rsp [TABLE_DEPTH];
  link_t     link [TABLE_DEPTH+1];

  ger_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp       (rsp),
    .tail      (link[TABLE_DEPTH]),
    .cmd       (cmd),
    .head      (link[0])
  );

  // link[i] feeds cell i; link[i+1] shows what cell i holds now
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ger_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .rsp      (rsp[i])
    );
  end

endmodule

`default_nettype wire
